// ----- rtl/core/permutation_unrank_assert.svh -----
// Assertion helpers for the permutation_unrank checker.
// Both sample on the rising edge of clock.
`ifndef PERMUTATION_UNRANK_ASSERT_SVH
`define PERMUTATION_UNRANK_ASSERT_SVH

// Property that is ignored while reset is high.
`define PU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that is also checked while reset is high.
`define PU_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/pu_pkg.sv -----
package pu_pkg;

   localparam int RANK_W     = 64;
   localparam int SYM_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int SYM_LIMIT  = 16;  // symbols are 4 bits wide

   // Divider retires this many quotient bits per cycle.
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = RANK_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_ALPHABET_SIZE      = 2'd0;
   localparam csr_idx_type CSR_ARRANGEMENT_LENGTH = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic err;        // current config gives an error result
      logic last;       // the pending result is the final one of the rank
      logic slot_free;  // output register can take a word this cycle
   } status_type;

endpackage

// ----- rtl/core/pu_ctrl.sv -----
module pu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  pu_pkg::status_type status,
   output logic               req_ready,
   output pu_pkg::cmd_type    cmd
);
   import pu_pkg::*;

   localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   state_type             state_ff;
   state_type             state_in;
   logic [DIV_CNT_W-1:0]  step_ff;
   logic [DIV_CNT_W-1:0]  step_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.err ? ST_PUT : ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (status.slot_free) begin
               state_in = status.last ? ST_IDLE : ST_DIV;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_PUT: begin
            cmd.put = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.load) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = (step_ff == STEP_LAST) ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- rtl/core/pu_datapath.sv -----
module pu_datapath #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  pu_pkg::csr_idx_type           csr_index,
   input  logic [pu_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [pu_pkg::RANK_W-1:0]     req_rank_index,
   input  pu_pkg::cmd_type               cmd,
   output pu_pkg::status_type            status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pu_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                          rsp_last_symbol,
   output logic                          rsp_length_error
);
   import pu_pkg::*;

   localparam int CAP   = (MAX_SYMBOLS < SYM_LIMIT) ? MAX_SYMBOLS : SYM_LIMIT;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int IDX_W = $clog2(CAP);
   localparam logic [CSR_DATA_W-1:0] CAP_V = CSR_DATA_W'(CAP);

   // configuration
   logic [CSR_DATA_W-1:0] alpha_ff;
   logic [CSR_DATA_W-1:0] klen_ff;

   logic [CSR_DATA_W-1:0] n_eff;
   logic [CSR_DATA_W-1:0] len_eff;
   logic                  err_now;

   // per-rank working state
   logic                  err_ff;
   logic [CNT_W-1:0]      len_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      pos_ff;
   logic [RANK_W-1:0]     q_ff;
   logic [IDX_W-1:0]      rem_ff;
   logic [SYM_W-1:0]      list_ff [CAP];
   logic [SYM_W-1:0]      list_init [CAP];

   logic [RANK_W-1:0]     q_in;
   logic [IDX_W-1:0]      rem_in;
   logic [DIV_BITS-1:0]   qbits;
   logic [IDX_W:0]        divisor;

   // output register
   logic                  rsp_valid_ff;
   logic [SYM_W-1:0]      rsp_symbol_ff;
   logic                  rsp_last_ff;
   logic                  rsp_err_ff;
   logic [SYM_W-1:0]      pick;

   always_comb begin
      n_eff   = (alpha_ff > CAP_V) ? CAP_V : alpha_ff;
      len_eff = (klen_ff != '0) ? klen_ff : n_eff;
      err_now = (n_eff == '0) || (len_eff > n_eff);
   end

   always_comb begin
      for (int c = 0; c < CAP; c++) begin
         list_init[c] = SYM_W'(n_eff - CSR_DATA_W'(c) - 1'b1);
      end
   end

   // DIV_BITS steps of restoring division by the remaining count
   always_comb begin
      logic [IDX_W:0]   trial;
      logic [IDX_W-1:0] r;
      divisor = (IDX_W + 1)'(cnt_ff);
      r       = rem_ff;
      qbits   = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, q_ff[RANK_W-1-i]};
         if (trial >= divisor) begin
            trial                 = trial - divisor;
            qbits[DIV_BITS-1-i]   = 1'b1;
         end
         r = trial[IDX_W-1:0];
      end
      rem_in = r;
      q_in   = {q_ff[RANK_W-DIV_BITS-1:0], qbits};
   end

   assign pick = err_ff ? '0 : list_ff[rem_ff];

   always_comb begin
      status.err       = err_now;
      status.last      = err_ff || (({1'b0, pos_ff} + 1'b1) == {1'b0, len_ff});
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= CSR_DATA_W'(1);
         klen_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ALPHABET_SIZE:      alpha_ff <= csr_data;
            CSR_ARRANGEMENT_LENGTH: klen_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
         cnt_ff <= '0;
         pos_ff <= '0;
         len_ff <= '0;
         q_ff   <= '0;
         rem_ff <= '0;
      end else if (cmd.load) begin
         err_ff <= err_now;
         cnt_ff <= n_eff[CNT_W-1:0];
         len_ff <= len_eff[CNT_W-1:0];
         pos_ff <= '0;
         q_ff   <= req_rank_index;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end else if (cmd.put) begin
         cnt_ff <= cnt_ff - 1'b1;
         pos_ff <= pos_ff + 1'b1;
         rem_ff <= '0;
      end
   end

   // symbol list: refilled per rank, gap closed on each pick
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int c = 0; c < CAP; c++) begin
            list_ff[c] <= list_init[c];
         end
      end else if (cmd.put) begin
         for (int c = 0; c < CAP - 1; c++) begin
            if (IDX_W'(c) >= rem_ff) begin
               list_ff[c] <= list_ff[c+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_symbol_ff <= pick;
         rsp_last_ff   <= status.last;
         rsp_err_ff    <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_last_symbol  = rsp_last_ff;
   assign rsp_length_error = rsp_err_ff;

endmodule

// ----- rtl/core/permutation_unrank.sv -----
// Channel  Direction  Handshake             Word
// req      in         req_valid/req_ready   req_rank_index
// rsp      out        rsp_valid/rsp_ready   rsp_symbol, rsp_last_symbol, rsp_length_error
// csr      in         csr_write_en          csr_index, csr_data
//
// One rank at a time. Each position runs the 64-bit quotient through the shared
// radix-256 divider and then writes the output register.
// An error rank skips the divider and gives one word.
// Output stalls hold the pick cycle; the next rank is taken while the final
// word still waits in the output register.
// Synchronous reset clears control state and restores the register defaults.
module permutation_unrank #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  pu_pkg::csr_idx_type           csr_index,
   input  logic [pu_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pu_pkg::RANK_W-1:0]     req_rank_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pu_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                          rsp_last_symbol,
   output logic                          rsp_length_error
);
   import pu_pkg::*;

   cmd_type    cmd;
   status_type status;

   pu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   pu_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_rank_index   (req_rank_index),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_symbol  (rsp_last_symbol),
      .rsp_length_error (rsp_length_error)
   );

endmodule

// ----- rtl/core/pu_checker.sv -----
`include "permutation_unrank_assert.svh"

module pu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pu_pkg::SYM_W-1:0]      rsp_symbol,
   input logic                          rsp_last_symbol,
   input logic                          rsp_length_error
);

   // no result word survives reset
   `PU_ASSERT_RST(a_rst_no_rsp, reset |=> !rsp_valid, "rsp_valid after reset")

   // the block works on one rank at a time
   `PU_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "req taken while busy")

   // an error word is alone and carries symbol zero
   `PU_ASSERT(a_err_word, rsp_valid && rsp_length_error |-> rsp_last_symbol && rsp_symbol == 4'd0, "bad error word")

   // a stalled word holds
   `PU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol), "rsp word dropped")

endmodule

bind permutation_unrank pu_checker u_pu_checker (.*);

// ----- test/permutation_unrank_tb.sv -----
module permutation_unrank_tb;
   import pu_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned RANDOM_ITEMS = 300;

   // indexes the block does not decode
   localparam csr_idx_type CSR_UNUSED_2 = 2'd2;
   localparam csr_idx_type CSR_UNUSED_3 = 2'd3;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             err;
   } symbol_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   csr_idx_type           csr_index = CSR_ALPHABET_SIZE;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [RANK_W-1:0]     req_rank_index = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SYM_W-1:0]      rsp_symbol;
   logic                  rsp_last_symbol;
   logic                  rsp_length_error;

   // configuration as the block should hold it
   logic [CSR_DATA_W-1:0] cfg_alphabet = 5'd1;
   logic [CSR_DATA_W-1:0] cfg_length = 5'd0;

   logic [RANK_W-1:0] rank_queue[$];
   symbol_word_type   expected_symbols[$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                idle_on = 1'b1;
   logic              hold_req = 1'b0;
   logic              hold_seen = 1'b0;
   int unsigned       hold_left = 0;
   int unsigned       req_gap = 0;
   int unsigned       rsp_gap = 0;

   permutation_unrank i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rank_index   (req_rank_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_symbol  (rsp_last_symbol),
      .rsp_length_error (rsp_length_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      logic [RANK_W-1:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return RANK_W'($urandom_range(0, 1000));
         1: return full >> $urandom_range(1, 63);
         2: return '1;
         3: return full >> $urandom_range(16, 40);
         default: return full;
      endcase
   endfunction

   task automatic add_rank(input logic [RANK_W-1:0] rank);
      rank_queue.insert(rank_queue.size(), rank);
   endtask

   task automatic add_expected(input symbol_word_type w);
      expected_symbols.insert(expected_symbols.size(), w);
   endtask

   // mixed-radix unranking: pick q mod count from the list, q /= count
   task automatic unrank_arrangement(input logic [RANK_W-1:0] rank);
      int unsigned      n, len, cnt, sel, c, p;
      logic [SYM_W-1:0] pool[SYM_LIMIT];
      logic [RANK_W-1:0] q;
      symbol_word_type  w;
      n = (cfg_alphabet > SYM_LIMIT) ? SYM_LIMIT : cfg_alphabet;
      len = (cfg_length != 0) ? cfg_length : n;
      if (n == 0 || len > n) begin
         w.symbol = '0;
         w.last = 1'b1;
         w.err = 1'b1;
         add_expected(w);
         return;
      end
      for (c = 0; c < n; c++) pool[c] = SYM_W'(n - 1 - c);
      cnt = n;
      q = rank;
      for (p = 1; p <= len; p++) begin
         sel = 32'(q % RANK_W'(cnt));
         q = q / RANK_W'(cnt);
         w.symbol = pool[sel];
         w.last = (p == len);
         w.err = 1'b0;
         add_expected(w);
         for (c = sel; c + 1 < cnt; c++) pool[c] = pool[c + 1];
         cnt--;
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) unrank_arrangement(req_rank_index);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (rank_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_rank_index <= rank_queue.pop_front();
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with the long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      symbol_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_symbols.size() == 0) begin
            flag_mismatch($sformatf("unexpected word sym=%0d last=%b err=%b",
               rsp_symbol, rsp_last_symbol, rsp_length_error));
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_symbol !== want.symbol || rsp_last_symbol !== want.last ||
                rsp_length_error !== want.err) begin
               flag_mismatch($sformatf("exp sym=%0d last=%b err=%b, got sym=%0d last=%b err=%b",
                  want.symbol, want.last, want.err,
                  rsp_symbol, rsp_last_symbol, rsp_length_error));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[permutation_unrank] ERROR");
         $finish;
      end
   end

   task automatic wait_idle();
      @(posedge clock);
      while (rank_queue.size() != 0 || req_valid || expected_symbols.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_ALPHABET_SIZE) cfg_alphabet = val;
      else if (idx == CSR_ARRANGEMENT_LENGTH) cfg_length = val;
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] n, input logic [CSR_DATA_W-1:0] k);
      wait_idle();
      write_reg(CSR_ALPHABET_SIZE, n);
      write_reg(CSR_ARRANGEMENT_LENGTH, k);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned random_items;
      int unsigned phase_len;
      int unsigned r, n, k, ne, ke;
      bit          bad_len;
      random_items = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults: one symbol, full length
      @(negedge clock);
      add_rank('0);
      add_rank('1);

      set_config(5'd16, 5'd0);
      add_rank('0);
      add_rank('1);
      add_rank(64'd1);
      add_rank(64'h8000_0000_0000_0000);
      add_rank(64'h5555_5555_5555_5555);
      add_rank(64'hAAAA_AAAA_AAAA_AAAA);
      add_rank(64'd20922789887999);  // 16! - 1
      add_rank(64'd20922789888000);  // 16! wraps around

      set_config(5'd16, 5'd16);
      add_rank('1);
      set_config(5'd16, 5'd17);                   // length too long
      add_rank(64'd5);
      set_config(5'd0, 5'd0);                     // empty alphabet
      add_rank(64'd7);
      set_config(5'd31, 5'd0);                    // saturates to 16
      add_rank(pick_rank());
      set_config(5'd31, 5'd31);
      add_rank(64'd3);
      set_config(5'd5, 5'd5);
      add_rank(64'd119);
      add_rank(64'd120);
      set_config(5'd2, 5'd1);
      add_rank(64'd0);
      add_rank(64'd1);

      // undecoded indexes must leave the 2/1 setting alone
      wait_idle();
      write_reg(CSR_UNUSED_2, 5'd0);
      write_reg(CSR_UNUSED_3, 5'd31);
      @(negedge clock);
      add_rank(64'd12345);

      // long receiver hold-off while the sender keeps pushing
      set_config(5'd16, 5'd16);
      idle_on = 1'b0;
      hold_req <= ~hold_req;
      repeat (5) add_rank(pick_rank());

      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            n = $urandom_range(1, 16);
            k = $urandom_range(0, n);
         end else if (r < 88) begin
            n = $urandom_range(17, 31);
            k = $urandom_range(0, 16);
         end else if (r < 94) begin
            n = $urandom_range(0, 15);
            k = $urandom_range(n + 1, 31);
         end else begin
            n = $urandom_range(0, 1) ? 16 : 1;
            k = $urandom_range(0, 1) ? n : 0;
         end
         ne = (n > SYM_LIMIT) ? SYM_LIMIT : n;
         ke = (k != 0) ? k : ne;
         bad_len = (ne == 0 || ke > ne);
         if ($urandom_range(0, 9) == 0) begin
            wait_idle();
            write_reg($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3,
                      CSR_DATA_W'($urandom_range(0, 31)));
         end
         set_config(CSR_DATA_W'(n), CSR_DATA_W'(k));
         idle_on = ($urandom_range(0, 3) != 0);
         phase_len = bad_len ? $urandom_range(1, 4) : $urandom_range(4, 30);
         repeat (phase_len) add_rank(pick_rank());
         random_items += phase_len;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_symbols.size() != 0)
         flag_mismatch($sformatf("%0d expected words never came", expected_symbols.size()));
      if (mismatch_count == 0) begin
         $display("[permutation_unrank] OK");
      end else begin
         $display("[permutation_unrank] ERROR");
      end
      $finish;
   end

endmodule

// ----- permutation_unrank.f -----
+incdir+rtl/core
rtl/core/pu_pkg.sv
rtl/core/pu_ctrl.sv
rtl/core/pu_datapath.sv
rtl/core/permutation_unrank.sv
rtl/core/pu_checker.sv
test/permutation_unrank_tb.sv
